// ===== hw/rtl/lpa_pkg.sv =====
package lpa_pkg;

  localparam int LABEL_COUNT   = 65536;
  localparam int MAX_DIMENSION = 16384;

  localparam int ADDR_W  = $clog2(LABEL_COUNT);
  localparam int CODE_W  = 16;
  localparam int COORD_W = 14;
  localparam int DIM_W   = 15;
  localparam int CNT_W   = 29;
  localparam int CAT_NUM = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CNT_W-1:0]   CNT_MAX    = '1;
  localparam logic [COORD_W-1:0] COORD_ONES = '1;

  localparam int CAT_CONTENT     = 0;
  localparam int CAT_BLACK       = 1;
  localparam int CAT_UNRESOLVED  = 2;
  localparam int CAT_BACKGROUND  = 3;
  localparam int CAT_OWNED_BLACK = 4;

  typedef enum logic [1:0] {
    OP_PIXEL  = 2'd0,
    OP_LABEL  = 2'd1,
    OP_TOTALS = 2'd2,
    OP_NONE   = 2'd3
  } lpa_op_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } lpa_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_HOLD
  } lpa_state_t;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   content;
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] max_y;
  } lpa_entry_t;

  localparam lpa_entry_t ENTRY_RESET = '{
    count:   '0,
    content: '0,
    min_x:   COORD_ONES,
    min_y:   COORD_ONES,
    max_x:   '0,
    max_y:   '0
  };

  typedef struct packed {
    logic [CNT_W-1:0]   label_pixels;
    logic [CNT_W-1:0]   label_content_pixels;
    logic [COORD_W-1:0] label_min_x;
    logic [COORD_W-1:0] label_min_y;
    logic [DIM_W-1:0]   label_end_x;
    logic [DIM_W-1:0]   label_end_y;
    logic [CNT_W-1:0]   content_total;
    logic [CNT_W-1:0]   black_total;
    logic [CNT_W-1:0]   unresolved_total;
    logic [CNT_W-1:0]   background_total;
    logic [CNT_W-1:0]   owned_black_total;
    logic               frame_release;
  } lpa_result_t;

  typedef struct packed {
    logic clear_we;
    logic in_ready;
    logic take;
    logic pix_update;
    logic load_out;
  } lpa_cmd_t;

  typedef struct packed {
    logic    in_valid;
    logic    clear_last;
    logic    out_free;
    lpa_op_t op_q;
  } lpa_sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== hw/rtl/lpa_if.sv =====
interface lpa_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic [7:0]                 red;
  logic [7:0]                 green;
  logic [7:0]                 blue;
  logic [lpa_pkg::CODE_W-1:0] owner_code;

  modport source (output valid, command, red, green, blue, owner_code, input ready);
  modport sink (input valid, command, red, green, blue, owner_code, output ready);
endinterface

interface lpa_out_if;
  logic                        valid;
  logic                        ready;
  logic [lpa_pkg::CNT_W-1:0]   label_pixels;
  logic [lpa_pkg::CNT_W-1:0]   label_content_pixels;
  logic [lpa_pkg::COORD_W-1:0] label_min_x;
  logic [lpa_pkg::COORD_W-1:0] label_min_y;
  logic [lpa_pkg::DIM_W-1:0]   label_end_x;
  logic [lpa_pkg::DIM_W-1:0]   label_end_y;
  logic [lpa_pkg::CNT_W-1:0]   content_total;
  logic [lpa_pkg::CNT_W-1:0]   black_total;
  logic [lpa_pkg::CNT_W-1:0]   unresolved_total;
  logic [lpa_pkg::CNT_W-1:0]   background_total;
  logic [lpa_pkg::CNT_W-1:0]   owned_black_total;
  logic                        frame_release;

  modport source (
    output valid, label_pixels, label_content_pixels, label_min_x, label_min_y,
           label_end_x, label_end_y, content_total, black_total, unresolved_total,
           background_total, owned_black_total, frame_release,
    input  ready
  );
  modport sink (
    input  valid, label_pixels, label_content_pixels, label_min_x, label_min_y,
           label_end_x, label_end_y, content_total, black_total, unresolved_total,
           background_total, owned_black_total, frame_release,
    output ready
  );
endinterface

// ===== hw/rtl/lpa_cfg.sv =====
module lpa_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lpa_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [lpa_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [lpa_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready,
  output logic [lpa_pkg::DIM_W-1:0]   width_eff,
  output logic [lpa_pkg::DIM_W-1:0]   height_eff,
  output logic                        frame_restart
);

  logic [lpa_pkg::DIM_W-1:0] width_r;
  logic [lpa_pkg::DIM_W-1:0] width_nxt;
  logic [lpa_pkg::DIM_W-1:0] height_r;
  logic [lpa_pkg::DIM_W-1:0] height_nxt;
  logic                      wr_en;
  lpa_pkg::lpa_reg_t         reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_sel    = lpa_pkg::lpa_reg_t'(cfg_paddr[2]);

  always_comb begin
    width_nxt     = width_r;
    height_nxt    = height_r;
    frame_restart = 1'b0;
    if (wr_en) begin
      frame_restart = 1'b1;
      case (reg_sel)
        lpa_pkg::REG_WIDTH:  width_nxt  = cfg_pwdata[lpa_pkg::DIM_W-1:0];
        lpa_pkg::REG_HEIGHT: height_nxt = cfg_pwdata[lpa_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lpa_pkg::DIM_W'(lpa_pkg::MAX_DIMENSION);
      height_r <= lpa_pkg::DIM_W'(lpa_pkg::MAX_DIMENSION);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      lpa_pkg::REG_WIDTH:  cfg_prdata = lpa_pkg::PDATA_W'(width_r);
      lpa_pkg::REG_HEIGHT: cfg_prdata = lpa_pkg::PDATA_W'(height_r);
      default:             cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (width_r == '0) begin
      width_eff = lpa_pkg::DIM_W'(1);
    end else if (32'(width_r) > lpa_pkg::MAX_DIMENSION) begin
      width_eff = lpa_pkg::DIM_W'(lpa_pkg::MAX_DIMENSION);
    end else begin
      width_eff = width_r;
    end
    if (height_r == '0) begin
      height_eff = lpa_pkg::DIM_W'(1);
    end else if (32'(height_r) > lpa_pkg::MAX_DIMENSION) begin
      height_eff = lpa_pkg::DIM_W'(lpa_pkg::MAX_DIMENSION);
    end else begin
      height_eff = height_r;
    end
  end

endmodule

// ===== hw/rtl/lpa_ctrl.sv =====
module lpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  lpa_pkg::lpa_sts_t sts,
  output lpa_pkg::lpa_cmd_t cmd
);

  lpa_pkg::lpa_state_t state_r;
  lpa_pkg::lpa_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpa_pkg::ST_CLEAR: begin
        if (sts.clear_last) state_nxt = lpa_pkg::ST_IDLE;
      end
      lpa_pkg::ST_IDLE: begin
        if (sts.in_valid) state_nxt = lpa_pkg::ST_EXEC;
      end
      lpa_pkg::ST_EXEC: begin
        case (sts.op_q)
          lpa_pkg::OP_LABEL, lpa_pkg::OP_TOTALS: begin
            state_nxt = sts.out_free ? lpa_pkg::ST_IDLE : lpa_pkg::ST_HOLD;
          end
          default: state_nxt = lpa_pkg::ST_IDLE;
        endcase
      end
      lpa_pkg::ST_HOLD: begin
        if (sts.out_free) state_nxt = lpa_pkg::ST_IDLE;
      end
      default: state_nxt = lpa_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      lpa_pkg::ST_CLEAR: cmd.clear_we = 1'b1;
      lpa_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.take     = sts.in_valid;
      end
      lpa_pkg::ST_EXEC: begin
        case (sts.op_q)
          lpa_pkg::OP_PIXEL:                     cmd.pix_update = 1'b1;
          lpa_pkg::OP_LABEL, lpa_pkg::OP_TOTALS: cmd.load_out   = sts.out_free;
          default: ;
        endcase
      end
      lpa_pkg::ST_HOLD: cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpa_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded while the output register is occupied");

  a_take_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> state_r == lpa_pkg::ST_EXEC)
    else $error("accepted request not executed in the next cycle");

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lpa_pkg::ST_CLEAR |-> !cmd.in_ready && !cmd.pix_update)
    else $error("request handled during the clearing pass");

endmodule

// ===== hw/rtl/lpa_datapath.sv =====
module lpa_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  lpa_in_if.sink                    in_ch,
  lpa_out_if.source                 out_ch,
  input  logic [lpa_pkg::DIM_W-1:0] width_eff,
  input  logic [lpa_pkg::DIM_W-1:0] height_eff,
  input  logic                      frame_restart,
  input  lpa_pkg::lpa_cmd_t         cmd,
  output lpa_pkg::lpa_sts_t         sts
);

  lpa_pkg::lpa_entry_t mem [lpa_pkg::LABEL_COUNT];
  lpa_pkg::lpa_entry_t rd_r;
  lpa_pkg::lpa_entry_t upd_entry;
  lpa_pkg::lpa_entry_t mem_wdata;
  logic [lpa_pkg::ADDR_W-1:0] mem_waddr;
  logic                       mem_we;

  logic [lpa_pkg::ADDR_W-1:0] clr_addr_r;

  lpa_pkg::lpa_op_t           op_q_r;
  logic [lpa_pkg::CODE_W-1:0] code_q_r;
  logic                       content_q_r;

  logic [lpa_pkg::COORD_W-1:0] col_r;
  logic [lpa_pkg::COORD_W-1:0] col_nxt;
  logic [lpa_pkg::DIM_W-1:0]   row_r;
  logic [lpa_pkg::DIM_W-1:0]   row_nxt;
  logic [lpa_pkg::DIM_W-1:0]   col_inc;
  logic [lpa_pkg::COORD_W-1:0] y_coord;

  logic [lpa_pkg::CNT_W-1:0] cnt_r   [lpa_pkg::CAT_NUM];
  logic [lpa_pkg::CNT_W-1:0] cnt_nxt [lpa_pkg::CAT_NUM];

  lpa_pkg::lpa_result_t res_r;
  lpa_pkg::lpa_result_t res_nxt;
  logic                 out_valid_r;

  logic in_frame;
  logic label_ok;
  logic pix_go;

  assign in_ch.ready = cmd.in_ready;

  assign in_frame = row_r < height_eff;
  assign label_ok = (code_q_r != '0) && (32'(code_q_r) < lpa_pkg::LABEL_COUNT);
  assign pix_go   = cmd.pix_update & in_frame;
  assign y_coord  = row_r[lpa_pkg::COORD_W-1:0];

  assign sts.in_valid   = in_ch.valid;
  assign sts.clear_last = clr_addr_r == lpa_pkg::ADDR_W'(lpa_pkg::LABEL_COUNT - 1);
  assign sts.out_free   = !out_valid_r || out_ch.ready;
  assign sts.op_q       = op_q_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q_r      <= lpa_pkg::lpa_op_t'(in_ch.command);
      code_q_r    <= in_ch.owner_code;
      content_q_r <= (in_ch.red | in_ch.green | in_ch.blue) != 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_we) begin
      clr_addr_r <= clr_addr_r + lpa_pkg::ADDR_W'(1);
    end
  end

  always_comb begin
    upd_entry         = rd_r;
    upd_entry.count   = lpa_pkg::sat_inc(rd_r.count);
    upd_entry.content = content_q_r ? lpa_pkg::sat_inc(rd_r.content) : rd_r.content;
    if (col_r < rd_r.min_x) upd_entry.min_x = col_r;
    if (y_coord < rd_r.min_y) upd_entry.min_y = y_coord;
    if (col_r > rd_r.max_x) upd_entry.max_x = col_r;
    if (y_coord > rd_r.max_y) upd_entry.max_y = y_coord;
  end

  always_comb begin
    if (cmd.clear_we) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = lpa_pkg::ENTRY_RESET;
    end else begin
      mem_we    = pix_go & label_ok;
      mem_waddr = code_q_r[lpa_pkg::ADDR_W-1:0];
      mem_wdata = upd_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) rd_r <= mem[in_ch.owner_code[lpa_pkg::ADDR_W-1:0]];
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_comb begin
    for (int i = 0; i < lpa_pkg::CAT_NUM; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    if (pix_go) begin
      if (content_q_r) begin
        cnt_nxt[lpa_pkg::CAT_CONTENT] = lpa_pkg::sat_inc(cnt_r[lpa_pkg::CAT_CONTENT]);
        if (code_q_r == '0) begin
          cnt_nxt[lpa_pkg::CAT_UNRESOLVED] =
            lpa_pkg::sat_inc(cnt_r[lpa_pkg::CAT_UNRESOLVED]);
        end
      end else begin
        cnt_nxt[lpa_pkg::CAT_BLACK] = lpa_pkg::sat_inc(cnt_r[lpa_pkg::CAT_BLACK]);
        if (code_q_r == '0) begin
          cnt_nxt[lpa_pkg::CAT_BACKGROUND] =
            lpa_pkg::sat_inc(cnt_r[lpa_pkg::CAT_BACKGROUND]);
        end else begin
          cnt_nxt[lpa_pkg::CAT_OWNED_BLACK] =
            lpa_pkg::sat_inc(cnt_r[lpa_pkg::CAT_OWNED_BLACK]);
        end
      end
    end
  end

  always_comb begin
    col_inc = {1'b0, col_r} + lpa_pkg::DIM_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (frame_restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (pix_go) begin
      if (col_inc >= width_eff) begin
        col_nxt = '0;
        row_nxt = row_r + lpa_pkg::DIM_W'(1);
      end else begin
        col_nxt = col_inc[lpa_pkg::COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int i = 0; i < lpa_pkg::CAT_NUM; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      for (int i = 0; i < lpa_pkg::CAT_NUM; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  always_comb begin
    res_nxt = '0;
    case (op_q_r)
      lpa_pkg::OP_LABEL: begin
        if (label_ok && rd_r.count != '0) begin
          res_nxt.label_pixels         = rd_r.count;
          res_nxt.label_content_pixels = rd_r.content;
          res_nxt.label_min_x          = rd_r.min_x;
          res_nxt.label_min_y          = rd_r.min_y;
          res_nxt.label_end_x          = {1'b0, rd_r.max_x} + lpa_pkg::DIM_W'(1);
          res_nxt.label_end_y          = {1'b0, rd_r.max_y} + lpa_pkg::DIM_W'(1);
        end else begin
          res_nxt.label_min_x = lpa_pkg::COORD_ONES;
          res_nxt.label_min_y = lpa_pkg::COORD_ONES;
        end
      end
      lpa_pkg::OP_TOTALS: begin
        res_nxt.content_total     = cnt_r[lpa_pkg::CAT_CONTENT];
        res_nxt.black_total       = cnt_r[lpa_pkg::CAT_BLACK];
        res_nxt.unresolved_total  = cnt_r[lpa_pkg::CAT_UNRESOLVED];
        res_nxt.background_total  = cnt_r[lpa_pkg::CAT_BACKGROUND];
        res_nxt.owned_black_total = cnt_r[lpa_pkg::CAT_OWNED_BLACK];
        res_nxt.frame_release     = !in_frame && (cnt_r[lpa_pkg::CAT_UNRESOLVED] == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.label_pixels         = res_r.label_pixels;
  assign out_ch.label_content_pixels = res_r.label_content_pixels;
  assign out_ch.label_min_x          = res_r.label_min_x;
  assign out_ch.label_min_y          = res_r.label_min_y;
  assign out_ch.label_end_x          = res_r.label_end_x;
  assign out_ch.label_end_y          = res_r.label_end_y;
  assign out_ch.content_total        = res_r.content_total;
  assign out_ch.black_total          = res_r.black_total;
  assign out_ch.unresolved_total     = res_r.unresolved_total;
  assign out_ch.background_total     = res_r.background_total;
  assign out_ch.owned_black_total    = res_r.owned_black_total;
  assign out_ch.frame_release        = res_r.frame_release;

  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load_out))
    else $error("output valid raised without a loaded result");

  a_column_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < width_eff || $past(frame_restart) == 1'b0 && $changed(width_eff))
    else $error("column counter reached the row width");

endmodule

// ===== hw/rtl/label_pixel_accounting.sv =====
// Per-label pixel accounting over a raster-order pixel stream.
// Requests arrive on in_ch (valid/ready): a pixel request carries an RGB triple
// and an owner label, a label read request returns that label's counts and
// bounding box, and a totals request returns the five category counters and
// the release flag. Pixel requests produce no response; read requests produce
// exactly one response on out_ch, held in an output register until taken.
// Each request is accepted in ST_IDLE, which also issues the label-store read,
// and is then executed in ST_EXEC, which updates the store or forms the response.
// A new request is accepted only after the previous one has been executed, and
// the response is loaded into the output register when it is formed. The label
// store does one read-modify-write per pixel.
// If the receiver stalls, the response stays in the output register and pixel
// requests keep flowing; the next read request is accepted but then holds the
// block, with in_ch.ready low, until the register is emptied. After reset the
// label store is cleared one entry per cycle; in_ch.ready stays low meanwhile,
// but register writes on the cfg_ port are taken. A register write restarts
// the frame position and keeps all counts.
module label_pixel_accounting (
  input  logic                        clk,
  input  logic                        rst_n,
  lpa_in_if.sink                      in_ch,
  lpa_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lpa_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [lpa_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [lpa_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  logic [lpa_pkg::DIM_W-1:0] width_eff;
  logic [lpa_pkg::DIM_W-1:0] height_eff;
  logic                      frame_restart;
  lpa_pkg::lpa_cmd_t         cmd;
  lpa_pkg::lpa_sts_t         sts;

  lpa_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .width_eff     (width_eff),
    .height_eff    (height_eff),
    .frame_restart (frame_restart)
  );

  lpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  lpa_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .width_eff     (width_eff),
    .height_eff    (height_eff),
    .frame_restart (frame_restart),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import lpa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 900_000;
  localparam int unsigned TARGET_ISSUED = 1850;
  localparam int unsigned QUIET_FROM = 1650;

  class pixel_tally;
    lpa_entry_t label_entries[int];
    logic [CNT_W-1:0] category_count[CAT_NUM];
    int unsigned column;
    int unsigned row;
    int unsigned width_reg;
    int unsigned height_reg;
    lpa_result_t awaited[$];
    int unsigned faults;

    function new();
      foreach (category_count[i]) category_count[i] = '0;
      column = 0;
      row = 0;
      width_reg = MAX_DIMENSION;
      height_reg = MAX_DIMENSION;
      faults = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v);
      if (v < 1) return 1;
      if (v > MAX_DIMENSION) return MAX_DIMENSION;
      return v;
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    function void write_reg(lpa_reg_t which, logic [DIM_W-1:0] v);
      if (which == REG_WIDTH) begin
        width_reg = v;
      end else begin
        height_reg = v;
      end
      column = 0;
      row = 0;
    endfunction

    // Returns 1 when the request has an effect: an in-frame pixel or a read.
    function bit account(lpa_op_t op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                         logic [CODE_W-1:0] code);
      lpa_result_t rep;
      lpa_entry_t e;
      bit content;
      int unsigned w;
      int unsigned h;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      rep = '0;
      case (op)
        OP_PIXEL: begin
          if (row >= h) return 0;
          content = |{r, g, b};
          x = COORD_W'(column);
          y = COORD_W'(row);
          if (content) begin
            category_count[CAT_CONTENT] = bump(category_count[CAT_CONTENT]);
            if (code == 0)
              category_count[CAT_UNRESOLVED] = bump(category_count[CAT_UNRESOLVED]);
          end else begin
            category_count[CAT_BLACK] = bump(category_count[CAT_BLACK]);
            if (code == 0)
              category_count[CAT_BACKGROUND] = bump(category_count[CAT_BACKGROUND]);
            else
              category_count[CAT_OWNED_BLACK] = bump(category_count[CAT_OWNED_BLACK]);
          end
          if (code != 0) begin
            e = label_entries.exists(code) ? label_entries[code] : ENTRY_RESET;
            e.count = bump(e.count);
            if (content) e.content = bump(e.content);
            if (x < e.min_x) e.min_x = x;
            if (y < e.min_y) e.min_y = y;
            if (x > e.max_x) e.max_x = x;
            if (y > e.max_y) e.max_y = y;
            label_entries[code] = e;
          end
          column = column + 1;
          if (column >= w) begin
            column = 0;
            row = row + 1;
          end
          return 1;
        end
        OP_LABEL: begin
          rep.label_min_x = COORD_ONES;
          rep.label_min_y = COORD_ONES;
          if (code != 0 && label_entries.exists(code)) begin
            e = label_entries[code];
            if (e.count != 0) begin
              rep.label_pixels = e.count;
              rep.label_content_pixels = e.content;
              rep.label_min_x = e.min_x;
              rep.label_min_y = e.min_y;
              rep.label_end_x = DIM_W'(e.max_x) + DIM_W'(1);
              rep.label_end_y = DIM_W'(e.max_y) + DIM_W'(1);
            end
          end
        end
        OP_TOTALS: begin
          rep.content_total = category_count[CAT_CONTENT];
          rep.black_total = category_count[CAT_BLACK];
          rep.unresolved_total = category_count[CAT_UNRESOLVED];
          rep.background_total = category_count[CAT_BACKGROUND];
          rep.owned_black_total = category_count[CAT_OWNED_BLACK];
          rep.frame_release = (row >= h) && (category_count[CAT_UNRESOLVED] == 0);
        end
        default: return 0;
      endcase
      awaited.push_back(rep);
      return 1;
    endfunction

    function void note_fault(string what, longint unsigned want, longint unsigned got);
      faults++;
      if (faults <= 10)
        $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endfunction

    function void check_report(lpa_result_t got);
      lpa_result_t want;
      if (awaited.size() == 0) begin
        note_fault("response with no request pending", 0, 1);
        return;
      end
      want = awaited.pop_front();
      if (got.label_pixels !== want.label_pixels)
        note_fault("label_pixels", want.label_pixels, got.label_pixels);
      if (got.label_content_pixels !== want.label_content_pixels)
        note_fault("label_content_pixels", want.label_content_pixels,
                   got.label_content_pixels);
      if (got.label_min_x !== want.label_min_x)
        note_fault("label_min_x", want.label_min_x, got.label_min_x);
      if (got.label_min_y !== want.label_min_y)
        note_fault("label_min_y", want.label_min_y, got.label_min_y);
      if (got.label_end_x !== want.label_end_x)
        note_fault("label_end_x", want.label_end_x, got.label_end_x);
      if (got.label_end_y !== want.label_end_y)
        note_fault("label_end_y", want.label_end_y, got.label_end_y);
      if (got.content_total !== want.content_total)
        note_fault("content_total", want.content_total, got.content_total);
      if (got.black_total !== want.black_total)
        note_fault("black_total", want.black_total, got.black_total);
      if (got.unresolved_total !== want.unresolved_total)
        note_fault("unresolved_total", want.unresolved_total, got.unresolved_total);
      if (got.background_total !== want.background_total)
        note_fault("background_total", want.background_total, got.background_total);
      if (got.owned_black_total !== want.owned_black_total)
        note_fault("owned_black_total", want.owned_black_total, got.owned_black_total);
      if (got.frame_release !== want.frame_release)
        note_fault("frame_release", want.frame_release, got.frame_release);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  lpa_in_if in_ch();
  lpa_out_if out_ch();

  pixel_tally tally = new();

  int unsigned cycle_count = 0;
  int unsigned issued = 0;
  int unsigned stall_left = 0;
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  bit quiet_tail = 1'b0;
  logic [CODE_W-1:0] label_pool [12];

  label_pixel_accounting dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0 && sink_idle_en && !quiet_tail && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 11);
    out_ch.ready = (stall_left == 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk) begin
    lpa_result_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.label_pixels, out_ch.label_content_pixels, out_ch.label_min_x,
             out_ch.label_min_y, out_ch.label_end_x, out_ch.label_end_y,
             out_ch.content_total, out_ch.black_total, out_ch.unresolved_total,
             out_ch.background_total, out_ch.owned_black_total, out_ch.frame_release};
      tally.check_report(got);
    end
  end

  task automatic send(lpa_op_t op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                      logic [CODE_W-1:0] code);
    if (src_idle_en && !quiet_tail && $urandom_range(0, 6) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.command = op;
    in_ch.red = r;
    in_ch.green = g;
    in_ch.blue = b;
    in_ch.owner_code = code;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    issued++;
    void'(tally.account(op, r, g, b, code));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (tally.awaited.size() != 0) @(negedge clk);
  endtask

  task automatic program_reg(lpa_reg_t which, logic [DIM_W-1:0] v);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {which, 2'b00};
    cfg_pwdata = {17'($urandom), v};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    tally.write_reg(which, v);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic set_frame(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    drain_results();
    repeat (8) @(negedge clk);
    if ($urandom_range(0, 1) == 0) begin
      program_reg(REG_WIDTH, w);
      program_reg(REG_HEIGHT, h);
    end else begin
      program_reg(REG_HEIGHT, h);
      program_reg(REG_WIDTH, w);
    end
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 24))
      0: return '0;
      1: return '1;
      2: return DIM_W'(MAX_DIMENSION);
      3: return DIM_W'($urandom_range(9, MAX_DIMENSION - 1));
      4: return DIM_W'($urandom_range(MAX_DIMENSION + 1, 32767));
      default: return DIM_W'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic random_request();
    int unsigned pick;
    logic [7:0] ch [3];
    logic [CODE_W-1:0] code;
    lpa_op_t op;
    pick = $urandom_range(0, 99);
    code = label_pool[$urandom_range(0, 11)];
    if ($urandom_range(0, 9) == 0) code = CODE_W'($urandom);
    ch[0] = 8'($urandom);
    ch[1] = 8'($urandom);
    ch[2] = 8'($urandom);
    if (pick < 72) begin
      op = OP_PIXEL;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: ch = '{8'h00, 8'h00, 8'h00};
        4: begin
          ch = '{8'h00, 8'h00, 8'h00};
          ch[$urandom_range(0, 2)] = 8'(1 << $urandom_range(0, 7));
        end
        default: ;
      endcase
      if ($urandom_range(0, 4) == 0) code = '0;
    end else if (pick < 85) begin
      op = OP_LABEL;
      if ($urandom_range(0, 9) == 0) code = '0;
    end else if (pick < 97) begin
      op = OP_TOTALS;
    end else begin
      op = OP_NONE;
    end
    send(op, ch[0], ch[1], ch[2], code);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = OP_PIXEL;
    in_ch.red = '0;
    in_ch.green = '0;
    in_ch.blue = '0;
    in_ch.owner_code = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // A two by two frame filled without any unlabeled content, so that the
    // totals read after it reports the frame as releasable.
    set_frame(15'd2, 15'd2);
    send(OP_TOTALS, 8'h00, 8'h00, 8'h00, 16'h0000);
    send(OP_LABEL, 8'hFF, 8'hFF, 8'hFF, 16'h0000);
    send(OP_PIXEL, 8'h00, 8'h00, 8'h00, 16'h0000);
    send(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    send(OP_PIXEL, 8'h00, 8'h01, 8'h00, 16'hAAAA);
    send(OP_PIXEL, 8'h00, 8'h00, 8'h00, 16'hAAAA);
    send(OP_PIXEL, 8'h00, 8'h00, 8'h80, 16'h0000);
    send(OP_TOTALS, 8'h00, 8'h00, 8'h00, 16'h0000);
    send(OP_LABEL, 8'h00, 8'h00, 8'h00, 16'hFFFF);
    send(OP_LABEL, 8'h00, 8'h00, 8'h00, 16'hAAAA);
    send(OP_LABEL, 8'h00, 8'h00, 8'h00, 16'h5555);
    send(OP_NONE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);

    // Out-of-range register values are clamped to one column and the full height.
    set_frame(15'd0, 15'h7FFF);
    send(OP_PIXEL, 8'h00, 8'h00, 8'h00, 16'h5555);
    send(OP_PIXEL, 8'h00, 8'hFF, 8'h00, 16'h5555);
    send(OP_LABEL, 8'h00, 8'h00, 8'h00, 16'h5555);
    send(OP_LABEL, 8'h00, 8'h00, 8'h00, 16'hFFFF);

    set_frame(DIM_W'(MAX_DIMENSION), 15'd1);
    send(OP_PIXEL, 8'h7F, 8'h00, 8'h00, 16'h0001);
    send(OP_PIXEL, 8'h00, 8'h00, 8'h00, 16'h0001);
    send(OP_PIXEL, 8'h7F, 8'h00, 8'h00, 16'h0000);
    send(OP_LABEL, 8'h00, 8'h00, 8'h00, 16'h0001);
    send(OP_TOTALS, 8'h00, 8'h00, 8'h00, 16'h0000);

    foreach (label_pool[i]) label_pool[i] = CODE_W'($urandom_range(1, 65535));
    label_pool[0] = 16'hFFFF;
    label_pool[1] = 16'h0001;

    while (issued < TARGET_ISSUED) begin
      quiet_tail = (issued >= QUIET_FROM);
      src_idle_en = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      set_frame(pick_dim(), pick_dim());
      label_pool[$urandom_range(2, 11)] = CODE_W'($urandom_range(1, 65535));
      repeat ($urandom_range(15, 90)) begin
        if ($urandom_range(0, 59) == 0) drain_results();
        random_request();
      end
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (tally.faults == 0 && tally.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
